### rtl/gke_pkg.sv
// Package with shared types, constants and the exponential table for the KDE engine.
`default_nettype none

package gke_pkg;

    // Field widths of the channels and the register port
    localparam int CoordW  = 16;
    localparam int PidxW   = 10;
    localparam int DidxW   = 4;
    localparam int DensW   = 17;
    localparam int ScaleW  = 24;
    localparam int DimsW   = 5;
    localparam int CountW  = 11;
    localparam int PaddrW  = 4;

    // Kernel datapath widths
    localparam int X16W    = 21;
    localparam int Log2eW  = 17;
    localparam int YW      = X16W + Log2eW;

    // log2(e) in Q.16
    localparam logic [Log2eW-1:0] Log2eQ16 = 17'd94548;

    // Command codes
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Register indexes
    typedef enum logic [1:0] {
        REG_SCALE = 2'd0,
        REG_DIMS  = 2'd1,
        REG_COUNT = 2'd2
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_EXPO,
        ST_YMUL,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef logic [DensW-1:0] rom_t [256];

    // Integer square root of a 64-bit value
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bq;
        int          k;
        v  = v_in;
        r  = '0;
        bq = 64'h4000_0000_0000_0000;
        for (k = 0; k < 32; k++) begin
            if (bq > v) begin
                bq = bq >> 2;
            end
        end
        for (k = 0; k < 32; k++) begin
            if (bq != 64'd0) begin
                if (v >= r + bq) begin
                    v = v - (r + bq);
                    r = (r >> 1) + bq;
                end else begin
                    r = r >> 1;
                end
                bq = bq >> 2;
            end
        end
        return r;
    endfunction

    // Build the 2^-f table, f = i/256, in Q1.16
    function automatic rom_t build_rom();
        rom_t         rom;
        logic [63:0]  root [8];
        logic [127:0] p;
        int           b;
        int           i;
        root[7] = isqrt64(64'h8000_0000_0000_0000);
        for (b = 6; b >= 0; b--) begin
            root[b] = isqrt64(root[b+1] << 32);
        end
        for (i = 0; i < 256; i++) begin
            p = 128'h1_0000_0000;
            for (b = 0; b < 8; b++) begin
                if (i[b]) begin
                    p = (p * {64'd0, root[b]}) >> 32;
                end
            end
            rom[i] = DensW'((p + 128'd32768) >> 16);
        end
        return rom;
    endfunction

    localparam rom_t ExpRom = build_rom();

endpackage

`default_nettype wire

### rtl/gke_if.sv
// Valid/ready channel interfaces for the KDE engine input and result beats.
`default_nettype none

interface gke_in_if import gke_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [PidxW-1:0]         point_index;
    logic [DidxW-1:0]         dim_index;
    logic signed [CoordW-1:0] coordinate;

    modport source (output valid, cmd, point_index, dim_index, coordinate, input ready);
    modport sink   (input valid, cmd, point_index, dim_index, coordinate, output ready);
endinterface

interface gke_out_if import gke_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DensW-1:0] density;

    modport source (output valid, density, input ready);
    modport sink   (input valid, density, output ready);
endinterface

`default_nettype wire

### rtl/gke_div.sv
// Restoring divider, one quotient bit per cycle, for the kernel sum mean.
`default_nettype none

module gke_div import gke_pkg::*; #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 11,
    parameter int QUO_W = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    output div_status_t       status,
    output logic [QUO_W-1:0]  quotient
);

    localparam int CntW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             take;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        take    = (rem_sh >= {1'b0, denom});
        rem_sub = rem_sh - {1'b0, denom};
    end

    // Step counter and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CntW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift the dividend through and collect quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg[QUO_W-1:0];

endmodule

`default_nettype wire

### rtl/gaussian_kde_exact_engine.sv
// Top level of the exact Gaussian kernel density engine.
// Store beats and query beats that are not the last dimension are written straight into the store or query vector.
// A last-dimension query starts a walk over the configured points, paced by the single
// store read port and the shared square, scale and exp unit per point.
// One item is worked at a time; a finished density waits in the output register.
// Reset clears the query vector, the registers to their defaults and all control; the
// point store is not cleared and needs no clearing pass.
`default_nettype none

module gaussian_kde_exact_engine import gke_pkg::*; #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [PaddrW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    gke_in_if.sink            sample,
    gke_out_if.source         estimate
);

    localparam int StoreDepth = MAX_POINTS * MAX_DIMS;
    localparam int SaW  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
    localparam int PcW  = $clog2(MAX_POINTS + 1);
    localparam int DcW  = $clog2(MAX_DIMS + 1);
    localparam int DiW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW   = 32 + ((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0);
    localparam int HW   = (CW + 1) / 2;
    localparam int XW   = ScaleW + CW;
    localparam int SW   = DensW + PcW;

    // Configuration registers
    logic [ScaleW-1:0] scale_reg;
    logic [DimsW-1:0]  dims_cfg_reg;
    logic [CountW-1:0] count_cfg_reg;
    logic              cfg_we;
    logic [1:0]        cfg_idx;

    // Sequencer
    state_t            state_reg, state_next;
    logic [PcW-1:0]    pt_reg, pt_next;
    logic [SaW-1:0]    base_reg, base_next;
    logic [DcW-1:0]    dim_reg, dim_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [DcW-1:0]    dims_eff;
    logic [PcW-1:0]    count_eff;

    // Store and datapath
    logic [CoordW-1:0] store_mem [StoreDepth];
    logic [CoordW-1:0] qvec_reg [MAX_DIMS];
    logic [CoordW-1:0] rdata_reg;
    logic [CoordW-1:0] q1_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic [31:0]       sq_reg;
    logic [XW-1:0]     plo_reg;
    logic [XW-1:0]     phi_reg;
    logic [X16W-1:0]   x16_reg;
    logic              over_reg;
    logic [YW-1:0]     y_reg;
    logic [DensW-1:0]  density_reg;
    logic              out_valid_reg;

    logic              in_fire;
    logic              q_ok;
    logic              q_last;
    logic              mem_we;
    logic              mem_re;
    logic [SaW-1:0]    mem_waddr;
    logic [SaW-1:0]    mem_raddr;
    logic              div_start;
    logic              out_load;
    logic [DensW-1:0]  kern;
    logic [16:0]       diff;
    logic [15:0]       mag;
    logic [XW-1:0]     x_full;
    div_status_t       div_status;
    logic [DensW-1:0]  quotient;

    // Register port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[PaddrW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= ScaleW'(65536);
            dims_cfg_reg  <= DimsW'(1);
            count_cfg_reg <= CountW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SCALE: scale_reg     <= pwdata[ScaleW-1:0];
                REG_DIMS:  dims_cfg_reg  <= pwdata[DimsW-1:0];
                REG_COUNT: count_cfg_reg <= pwdata[CountW-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SCALE: prdata = 32'(scale_reg);
            REG_DIMS:  prdata = 32'(dims_cfg_reg);
            REG_COUNT: prdata = 32'(count_cfg_reg);
            default:   prdata = '0;
        endcase
    end

    // Clamp the dimension and point counts into range
    always_comb
    begin
        if (dims_cfg_reg == '0)
            dims_eff = DcW'(1);
        else if (32'(dims_cfg_reg) > MAX_DIMS)
            dims_eff = DcW'(MAX_DIMS);
        else
            dims_eff = DcW'(dims_cfg_reg);

        if (count_cfg_reg == '0)
            count_eff = PcW'(1);
        else if (32'(count_cfg_reg) > MAX_POINTS)
            count_eff = PcW'(MAX_POINTS);
        else
            count_eff = PcW'(count_cfg_reg);
    end

    // Input decode
    assign sample.ready = (state_reg == ST_IDLE);
    assign in_fire      = sample.valid && sample.ready;
    assign q_ok         = (32'(sample.dim_index) < MAX_DIMS);
    assign q_last       = (32'(sample.dim_index) == 32'(dims_eff) - 32'd1);
    assign mem_we       = in_fire && (sample.cmd == CMD_STORE) &&
                          (32'(sample.point_index) < MAX_POINTS) && q_ok;
    assign mem_waddr    = SaW'(32'(sample.point_index) * MAX_DIMS + 32'(sample.dim_index));
    assign mem_raddr    = base_reg + SaW'(dim_reg);

    // Hold query coordinates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_DIMS; k++)
                qvec_reg[k] <= '0;
        end
        else if (in_fire && (sample.cmd == CMD_QUERY) && q_ok)
        begin
            qvec_reg[DiW'(sample.dim_index)] <= sample.coordinate;
        end
    end

    // Point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= sample.coordinate;
        if (mem_re)
            rdata_reg <= store_mem[mem_raddr];
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pt_reg    <= '0;
            base_reg  <= '0;
            dim_reg   <= '0;
            c_reg     <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pt_reg    <= pt_next;
            base_reg  <= base_next;
            dim_reg   <= dim_next;
            c_reg     <= c_next;
            sum_reg   <= sum_next;
        end
    end

    // Next state, walk counters and accumulators
    always_comb
    begin
        state_next = state_reg;
        pt_next    = pt_reg;
        base_next  = base_reg;
        dim_next   = dim_reg;
        c_next     = c_reg;
        sum_next   = sum_reg;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        kern       = '0;

        if (v2_reg)
            c_next = c_reg + CW'(sq_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (sample.cmd == CMD_QUERY) && q_ok && q_last)
                begin
                    state_next = ST_READ;
                    pt_next    = '0;
                    base_next  = '0;
                    dim_next   = '0;
                    c_next     = '0;
                    sum_next   = '0;
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
                if (dim_reg == dims_eff - DcW'(1))
                begin
                    dim_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    dim_next = dim_reg + DcW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = ST_MUL_LO;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_EXPO;
            ST_EXPO:   state_next = ST_YMUL;
            ST_YMUL:   state_next = ST_SCALE;
            ST_SCALE:
            begin
                if (over_reg || y_reg[YW-1])
                    kern = '0;
                else
                    kern = ExpRom[y_reg[31:24]] >> y_reg[36:32];
                sum_next = sum_reg + SW'(kern);
                if (pt_reg == count_eff - PcW'(1))
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    pt_next    = pt_reg + PcW'(1);
                    base_next  = base_reg + SaW'(MAX_DIMS);
                    c_next     = '0;
                    state_next = ST_READ;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || estimate.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Difference magnitude of one coordinate pair
    always_comb
    begin
        diff = {q1_reg[CoordW-1], q1_reg} - {rdata_reg[CoordW-1], rdata_reg};
        mag  = diff[16] ? 16'(-diff) : diff[15:0];
    end

    assign x_full = plo_reg + (phi_reg << HW);

    // Pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= mem_re;
            v2_reg <= v1_reg;
        end
    end

    // Datapath stages: square, scale in two halves, exponent split
    always_ff @(posedge clk)
    begin
        if (mem_re)
            q1_reg <= qvec_reg[dim_reg[DiW-1:0]];
        if (v1_reg)
            sq_reg <= mag * mag;
        if (state_reg == ST_MUL_LO)
            plo_reg <= XW'(scale_reg * c_reg[HW-1:0]);
        if (state_reg == ST_MUL_HI)
            phi_reg <= XW'(scale_reg * c_reg[CW-1:HW]);
        if (state_reg == ST_EXPO)
        begin
            over_reg <= (x_full > (XW'(1) << 36));
            x16_reg  <= x_full[36:16];
        end
        if (state_reg == ST_YMUL)
            y_reg <= x16_reg * Log2eQ16;
    end

    // Mean over the points
    gke_div #(
        .NUM_W (SW),
        .DEN_W (PcW),
        .QUO_W (DensW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (sum_next),
        .denom    (count_eff),
        .status   (div_status),
        .quotient (quotient)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (estimate.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            density_reg <= quotient;
    end

    assign estimate.valid   = out_valid_reg;
    assign estimate.density = density_reg;

    // Checks
    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_IDLE)
        else $error("store written during a walk");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL_LO |-> !v1_reg && !v2_reg)
        else $error("distance sum used before pipeline drained");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside divide state");

    a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> quotient <= DensW'(65536))
        else $error("density above one");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !out_valid_reg || estimate.ready)
        else $error("result overwritten before taken");

endmodule

`default_nettype wire
